// File: hdl/rounded_box_coverage_blend_unit_assert.svh
// Assertion macros shared by the rounded box blend RTL.
`ifndef ROUNDED_BOX_COVERAGE_BLEND_UNIT_ASSERT_SVH
`define ROUNDED_BOX_COVERAGE_BLEND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBCB_ASSERT_IMP(name, clk_i, rst_ni, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBCB_ASSERT_NXT(name, clk_i, rst_ni, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rbcb_pkg.sv
package rbcb_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int NUM_UNITS  = 8;

	localparam logic [1:0] MODE_FILL   = 2'd0;
	localparam logic [1:0] MODE_ROUND  = 2'd1;
	localparam logic [1:0] MODE_SHADOW = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_EDGE   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_FILL   = 3'd5;

	localparam logic [7:0]  FULL          = 8'd255;
	localparam logic [23:0] RGB_MASK      = 24'hffffff;
	localparam int          SHADOW_STEPS  = 7;
	localparam int          SHADOW_SAMPLES = 8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] box_width;
		logic [11:0] box_height;
		logic [6:0]  corner_radius;
		logic [5:0]  edge_size;
		logic [31:0] fill_color;
	} cfg_t;

	// Inset box of one test unit: offset and inset size.
	typedef struct packed {
		logic [6:0]         ofs;
		logic signed [12:0] w;
		logic signed [12:0] h;
	} unit_geom_t;

	// Clamped radius and the far corner band starts.
	typedef struct packed {
		logic [7:0]         rc;
		logic signed [12:0] wr;
		logic signed [12:0] hr;
	} unit_clamp_t;

endpackage

// File: hdl/rbcb_cfg.sv
module rbcb_cfg
	import rbcb_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [CFG_ADDR_W-1:0]              cfg_addr,
	input  logic [31:0]                        cfg_wdata,
	output cfg_t                               cfg,
	output unit_geom_t  [NUM_UNITS-1:0]        geom,
	output unit_clamp_t [NUM_UNITS-1:0]        clamp,
	output logic        [NUM_UNITS-1:0][17:0]  r4sq
);

	localparam logic [21:0] RECIP7 = 22'd2341;
	localparam int          RECIP7_SH = 14;

	logic [1:0]  mode_q;
	logic [11:0] box_width_q;
	logic [11:0] box_height_q;
	logic [6:0]  corner_radius_q;
	logic [5:0]  edge_size_q;
	logic [31:0] fill_color_q;

	unit_geom_t  [NUM_UNITS-1:0]       geom_d;
	logic        [NUM_UNITS-1:0][7:0]  rad_d;
	unit_geom_t  [NUM_UNITS-1:0]       geom_q;
	logic        [NUM_UNITS-1:0][7:0]  rad_q;
	unit_clamp_t [NUM_UNITS-1:0]       clamp_d;
	unit_clamp_t [NUM_UNITS-1:0]       clamp_q;
	logic        [NUM_UNITS-1:0][17:0] r4sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= '0;
			box_width_q     <= '0;
			box_height_q    <= '0;
			corner_radius_q <= '0;
			edge_size_q     <= '0;
			fill_color_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:   mode_q          <= cfg_wdata[1:0];
				REG_WIDTH:  box_width_q     <= cfg_wdata[11:0];
				REG_HEIGHT: box_height_q    <= cfg_wdata[11:0];
				REG_RADIUS: corner_radius_q <= cfg_wdata[6:0];
				REG_EDGE:   edge_size_q     <= cfg_wdata[5:0];
				REG_FILL:   fill_color_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Level 1: offset, radius and inset size of each unit.
	always_comb begin
		logic [9:0]        ring_v;
		logic [21:0]       ring_p;
		logic [6:0]        ins;
		logic signed [8:0] ring_r;
		logic [6:0]        ofs;
		logic [7:0]        rad;
		for (int k = 0; k < NUM_UNITS; k++) begin
			ring_v = 10'({4'b0, edge_size_q} * 10'((k >= 2) ? 2 * (k - 1) : 0));
			ring_p = {12'b0, ring_v} * RECIP7;
			ins    = ring_p[RECIP7_SH+6:RECIP7_SH];
			ring_r = $signed({2'b0, corner_radius_q}) + $signed({3'b0, edge_size_q})
				- $signed({2'b0, ins});
			if (k == 0) begin
				ofs = '0;
				rad = (mode_q == MODE_ROUND) ? {1'b0, corner_radius_q}
					: {1'b0, corner_radius_q} + {2'b0, edge_size_q};
			end else if (k == 1) begin
				ofs = (mode_q == MODE_ROUND) ? {1'b0, edge_size_q} : {edge_size_q, 1'b0};
				rad = ({1'b0, corner_radius_q} > {2'b0, edge_size_q})
					? {1'b0, corner_radius_q} - {2'b0, edge_size_q} : 8'd0;
			end else begin
				ofs = ins;
				rad = ring_r[8] ? 8'd0 : ring_r[7:0];
			end
			geom_d[k].ofs = ofs;
			geom_d[k].w   = $signed({1'b0, box_width_q}) - $signed({5'b0, ofs, 1'b0});
			geom_d[k].h   = $signed({1'b0, box_height_q}) - $signed({5'b0, ofs, 1'b0});
			rad_d[k]      = rad;
		end
	end

	// Level 2: clamp the radius to half the inset size.
	always_comb begin
		logic [11:0] hw;
		logic [11:0] hh;
		logic [11:0] m;
		for (int k = 0; k < NUM_UNITS; k++) begin
			hw = geom_q[k].w[12] ? 12'd0 : {1'b0, geom_q[k].w[11:1]};
			hh = geom_q[k].h[12] ? 12'd0 : {1'b0, geom_q[k].h[11:1]};
			m  = {4'b0, rad_q[k]};
			if (hw < m) m = hw;
			if (hh < m) m = hh;
			clamp_d[k].rc = m[7:0];
			clamp_d[k].wr = $signed(geom_q[k].w) - $signed({5'b0, m[7:0]});
			clamp_d[k].hr = $signed(geom_q[k].h) - $signed({5'b0, m[7:0]});
		end
	end

	// Refresh every cycle; the user must change config only while no pixel is in flight; not enforced here.
	always_ff @(posedge clk) begin
		geom_q  <= geom_d;
		rad_q   <= rad_d;
		clamp_q <= clamp_d;
		for (int k = 0; k < NUM_UNITS; k++) begin
			r4sq_q[k] <= {16'(clamp_q[k].rc * clamp_q[k].rc), 2'b00};
		end
	end

	assign cfg.mode          = mode_q;
	assign cfg.box_width     = box_width_q;
	assign cfg.box_height    = box_height_q;
	assign cfg.corner_radius = corner_radius_q;
	assign cfg.edge_size     = edge_size_q;
	assign cfg.fill_color    = fill_color_q;
	assign geom  = geom_q;
	assign clamp = clamp_q;
	assign r4sq  = r4sq_q;

endmodule

// File: hdl/rbcb_box_test.sv
module rbcb_box_test
	import rbcb_pkg::*;
(
	input  logic               clk,
	input  logic signed [12:0] x_s1,
	input  logic signed [12:0] y_s1,
	input  unit_geom_t         geom,
	input  unit_clamp_t        clamp,
	input  logic [17:0]        r4sq,
	output logic               hit_s5
);

	logic signed [13:0] xo_s2;
	logic signed [13:0] yo_s2;
	logic               inb_s2;
	logic [8:0]         dx_s3;
	logic [8:0]         dy_s3;
	logic               inb_s3;
	logic [17:0]        dx2_s4;
	logic [17:0]        dy2_s4;
	logic               inb_s4;

	logic signed [13:0] xo_d;
	logic signed [13:0] yo_d;
	logic signed [14:0] dx_w;
	logic signed [14:0] dy_w;
	logic [18:0]        sum_d;

	// Offset into the inset box and test its bounds.
	always_comb begin
		xo_d = $signed({x_s1[12], x_s1}) - $signed({7'b0, geom.ofs});
		yo_d = $signed({y_s1[12], y_s1}) - $signed({7'b0, geom.ofs});
	end

	// Distance into the corner band, doubled and centered on the pixel.
	function automatic logic signed [14:0] band_dist(
		input logic signed [13:0] p,
		input logic [7:0]         rc,
		input logic signed [12:0] far
	);
		logic signed [14:0] p15;
		logic signed [14:0] rc15;
		logic signed [14:0] far15;
		p15   = {p[13], p};
		rc15  = {7'b0, rc};
		far15 = {{2{far[12]}}, far};
		if (p15 < rc15)
			return ((rc15 - p15) <<< 1) - 15'sd1;
		else if (p15 >= far15)
			return ((p15 - far15) <<< 1) + 15'sd1;
		else
			return 15'sd0;
	endfunction

	always_comb begin
		dx_w  = band_dist(xo_s2, clamp.rc, clamp.wr);
		dy_w  = band_dist(yo_s2, clamp.rc, clamp.hr);
		sum_d = {1'b0, dx2_s4} + {1'b0, dy2_s4};
	end

	always_ff @(posedge clk) begin
		xo_s2  <= xo_d;
		yo_s2  <= yo_d;
		inb_s2 <= !xo_d[13] && !yo_d[13]
			&& (xo_d < $signed({geom.w[12], geom.w}))
			&& (yo_d < $signed({geom.h[12], geom.h}));

		dx_s3  <= inb_s2 ? dx_w[8:0] : 9'd0;
		dy_s3  <= inb_s2 ? dy_w[8:0] : 9'd0;
		inb_s3 <= inb_s2;

		dx2_s4 <= dx_s3 * dx_s3;
		dy2_s4 <= dy_s3 * dy_s3;
		inb_s4 <= inb_s3;

		hit_s5 <= inb_s4 && (dx2_s4 == '0 || dy2_s4 == '0 || sum_d <= {1'b0, r4sq});
	end

endmodule

// File: hdl/rbcb_shape.sv
`include "rounded_box_coverage_blend_unit_assert.svh"

module rbcb_shape
	import rbcb_pkg::*;
(
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [12:0]                pos_x,
	input  logic signed [12:0]                pos_y,
	input  logic [31:0]                       background,
	input  cfg_t                              cfg,
	input  unit_geom_t  [NUM_UNITS-1:0]       geom,
	input  unit_clamp_t [NUM_UNITS-1:0]       clamp,
	input  logic        [NUM_UNITS-1:0][17:0] r4sq,
	output logic                              v_s6,
	output logic [7:0]                        cov_s6,
	output logic [31:0]                       bg_s6
);

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [12:0]   x_s1;
	logic signed [12:0]   y_s1;
	logic [31:0]          bg_s1, bg_s2, bg_s3, bg_s4, bg_s5;
	logic [NUM_UNITS-1:0] hit_s5;
	logic [2:0]           hits;
	logic [10:0]          scaled;
	logic [7:0]           cov_d;

	genvar k;
	generate
		for (k = 0; k < NUM_UNITS; k++) begin : g_unit
			rbcb_box_test u_test (
				.clk    (clk),
				.x_s1   (x_s1),
				.y_s1   (y_s1),
				.geom   (geom[k]),
				.clamp  (clamp[k]),
				.r4sq   (r4sq[k]),
				.hit_s5 (hit_s5[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= pos_x;
		y_s1   <= pos_y;
		bg_s1  <= background;
		bg_s2  <= bg_s1;
		bg_s3  <= bg_s2;
		bg_s4  <= bg_s3;
		bg_s5  <= bg_s4;
		bg_s6  <= bg_s5;
		cov_s6 <= cov_d;
	end

	// Shadow ramp: one hit for the outer box plus one per inner ring, times 255 / 8.
	always_comb begin
		hits = 3'd1;
		for (int i = 2; i < NUM_UNITS; i++) begin
			hits = hits + {2'b0, hit_s5[i]};
		end
		scaled = {hits, 8'b0} - {8'b0, hits};
	end

	always_comb begin
		case (cfg.mode)
			MODE_FILL: cov_d = FULL;
			MODE_ROUND: begin
				if (!hit_s5[0])
					cov_d = 8'd0;
				else if (cfg.edge_size != '0 && hit_s5[1])
					cov_d = 8'd0;
				else
					cov_d = FULL;
			end
			default: begin
				if (cfg.edge_size == '0)
					cov_d = hit_s5[0] ? FULL : 8'd0;
				else if (!hit_s5[0])
					cov_d = 8'd0;
				else if (hit_s5[1])
					cov_d = FULL;
				else
					cov_d = scaled[10:3];
			end
		endcase
	end

	`RBCB_ASSERT_IMP(a_round_binary, clk, arst_n, v_s6 && cfg.mode == MODE_ROUND,
		cov_s6 == 8'd0 || cov_s6 == FULL, "round mode coverage not 0 or 255")

endmodule

// File: hdl/rbcb_blend.sv
`include "rounded_box_coverage_blend_unit_assert.svh"

module rbcb_blend
	import rbcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s6,
	input  logic [7:0]  cov_s6,
	input  logic [31:0] bg_s6,
	input  logic [31:0] fill_color,
	output logic        done,
	output logic [31:0] pixel,
	output logic [7:0]  coverage
);

	logic        v_s7, v_s8, done_s9;
	logic [7:0]  a_s7, a_s8;
	logic [7:0]  cov_s7, cov_s8, cov_s9;
	logic [31:0] bg_s7, bg_s8;
	logic [15:0] r_s8, g_s8, b_s8;
	logic [31:0] pixel_s9;
	logic [7:0]  na;
	logic [31:0] pixel_d;

	// Exact floor(x / 255) for any x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			done_s9 <= 1'b0;
		end else begin
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			done_s9 <= v_s8;
		end
	end

	always_comb begin
		na = FULL - a_s7;
		if (a_s8 == FULL)
			pixel_d = {8'h00, fill_color[23:0] & RGB_MASK};
		else if (a_s8 == 8'd0)
			pixel_d = bg_s8;
		else
			pixel_d = {8'h00, div255(r_s8), div255(g_s8), div255(b_s8)};
	end

	always_ff @(posedge clk) begin
		a_s7   <= div255(fill_color[31:24] * cov_s6);
		cov_s7 <= cov_s6;
		bg_s7  <= bg_s6;

		a_s8   <= a_s7;
		cov_s8 <= cov_s7;
		bg_s8  <= bg_s7;
		r_s8   <= fill_color[23:16] * a_s7 + bg_s7[23:16] * na;
		g_s8   <= fill_color[15:8] * a_s7 + bg_s7[15:8] * na;
		b_s8   <= fill_color[7:0] * a_s7 + bg_s7[7:0] * na;

		pixel_s9 <= pixel_d;
		cov_s9   <= cov_s8;
	end

	assign done     = done_s9;
	assign pixel    = pixel_s9;
	assign coverage = cov_s9;

	`RBCB_ASSERT_NXT(a_clear_keeps_bg, clk, arst_n, v_s8 && a_s8 == 8'd0,
		pixel_s9 == $past(bg_s8), "zero alpha altered background")

endmodule

// File: hdl/rounded_box_coverage_blend_unit.sv
// A pixel transferred on start passes stages s1 to s9 and shows on done from s9.
// Throughput: one pixel per clock; busy never rises, so start may stay high.
// The receiver cannot stall: each result shows for one cycle, strobed by done.
// Reset (arst_n low, asynchronous) clears the config registers to zero and
// drops every pipeline valid bit; derived box geometry refreshes each clock.
`include "rounded_box_coverage_blend_unit_assert.svh"

module rounded_box_coverage_blend_unit
	import rbcb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [12:0]    pos_x,
	input  logic signed [12:0]    pos_y,
	input  logic [31:0]           background,
	output logic                  done,
	output logic [31:0]           pixel,
	output logic [7:0]            coverage,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_wdata
);

	// Shape pipeline, stages 1 to 6:
	//   s1  capture position and background
	//   s2  offset into each of eight inset boxes, bounds test
	//   s3  doubled distance into the corner band on each axis
	//   s4  square both distances
	//   s5  compare the sum against four times the clamped radius squared
	//   s6  fold the eight hits into a coverage byte by mode
	// Unit 0 tests the outer box, unit 1 the stroke cut-out or shadow core,
	// units 2 to 7 the six shadow rings.
	// Blend pipeline, stages 7 to 9: alpha, channel sums, divide and select.
	//
	// Box geometry per unit is derived from the config registers through
	// three register levels that refresh every clock. Stage n reads level n-1
	// at most, so a pixel may start in the cycle after a config write.

	cfg_t                              cfg;
	unit_geom_t  [NUM_UNITS-1:0]       geom;
	unit_clamp_t [NUM_UNITS-1:0]       clamp;
	logic        [NUM_UNITS-1:0][17:0] r4sq;

	logic        accept;
	logic        v_s6;
	logic [7:0]  cov_s6;
	logic [31:0] bg_s6;

	// The pipeline never holds, so every start is a transfer.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	rbcb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.geom      (geom),
		.clamp     (clamp),
		.r4sq      (r4sq)
	);

	rbcb_shape u_shape (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.background (background),
		.cfg        (cfg),
		.geom       (geom),
		.clamp      (clamp),
		.r4sq       (r4sq),
		.v_s6       (v_s6),
		.cov_s6     (cov_s6),
		.bg_s6      (bg_s6)
	);

	rbcb_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s6       (v_s6),
		.cov_s6     (cov_s6),
		.bg_s6      (bg_s6),
		.fill_color (cfg.fill_color),
		.done       (done),
		.pixel      (pixel),
		.coverage   (coverage)
	);

	// Plain fill always covers the pixel fully.
	`RBCB_ASSERT_IMP(a_fill_full, clk, arst_n, done && cfg.mode == MODE_FILL,
		coverage == FULL, "fill mode coverage not full")

	// Opaque fill at full coverage replaces the pixel with the fill RGB.
	`RBCB_ASSERT_IMP(a_opaque_fill, clk, arst_n,
		done && coverage == FULL && cfg.fill_color[31:24] == FULL,
		pixel[31:24] == 8'h00 && pixel[23:0] == cfg.fill_color[23:0],
		"opaque covered pixel not fill color")

endmodule
